>>> src/mlkr_pkg.sv
// ----------------------------------------------------------------------------
// mlkr_pkg - shared types and key tables for the modifier layer remapper
// Event classes, key codes, the remap table and the job record handed from
// the decoder to the emitter.
// ----------------------------------------------------------------------------
package mlkr_pkg;

  localparam int unsigned TYPE_W  = 16;
  localparam int unsigned CODE_W  = 16;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned NUM_REMAP = 10;
  localparam int unsigned STEP_W  = 2;

  localparam logic [TYPE_W-1:0] EV_KEY = 16'd1;

  localparam logic [CODE_W-1:0] CODE_LMETA    = 16'd125;
  localparam logic [CODE_W-1:0] KEY_J         = 16'd36;
  localparam logic [CODE_W-1:0] KEY_K         = 16'd37;
  localparam logic [CODE_W-1:0] KEY_I         = 16'd23;
  localparam logic [CODE_W-1:0] KEY_L         = 16'd38;
  localparam logic [CODE_W-1:0] KEY_M         = 16'd50;
  localparam logic [CODE_W-1:0] CODE_COMMA    = 16'd51;
  localparam logic [CODE_W-1:0] KEY_U         = 16'd22;
  localparam logic [CODE_W-1:0] KEY_O         = 16'd24;
  localparam logic [CODE_W-1:0] KEY_H         = 16'd35;
  localparam logic [CODE_W-1:0] KEY_SEMICOLON = 16'd39;

  localparam logic [VALUE_W-1:0] VAL_RELEASE = 32'd0;
  localparam logic [VALUE_W-1:0] VAL_PRESS   = 32'd1;
  localparam logic [VALUE_W-1:0] VAL_REPEAT  = 32'd2;

  // Listed in release order: entry i is bit i of the held mask.
  localparam logic [CODE_W-1:0] SRC_CODES [NUM_REMAP] = '{
    KEY_I, KEY_K, KEY_J, KEY_L, KEY_M, CODE_COMMA, KEY_O, KEY_U, KEY_H, KEY_SEMICOLON
  };
  localparam logic [CODE_W-1:0] DST_CODES [NUM_REMAP] = '{
    16'd103, 16'd108, 16'd105, 16'd106, 16'd102,
    16'd107, 16'd104, 16'd109, 16'd14,  16'd111
  };

  typedef enum logic [1:0] {
    JOB_PASS,
    JOB_REMAP,
    JOB_META_REL
  } job_kind_e;

  typedef logic [NUM_REMAP-1:0] remap_mask_t;

  typedef struct packed {
    job_kind_e           kind;
    logic [TYPE_W-1:0]   ev_type;
    logic [CODE_W-1:0]   ev_code;
    logic [VALUE_W-1:0]  ev_value;
    remap_mask_t         mask;
    logic                press;
  } job_t;

  typedef struct packed {
    logic [TYPE_W-1:0]   ev_type;
    logic [CODE_W-1:0]   ev_code;
    logic [VALUE_W-1:0]  ev_value;
    logic                last;
  } result_t;

  // One-hot match of a code against the remap source table.
  function automatic remap_mask_t remap_match(input logic [CODE_W-1:0] code);
    remap_mask_t m;
    for (int i = 0; i < NUM_REMAP; i++) begin
      m[i] = (code == SRC_CODES[i]);
    end
    return m;
  endfunction

  // Target code for a one-hot selection (zero when nothing is selected).
  function automatic logic [CODE_W-1:0] remap_dst(input remap_mask_t sel);
    logic [CODE_W-1:0] c;
    c = '0;
    for (int i = 0; i < NUM_REMAP; i++) begin
      c = c | (DST_CODES[i] & {CODE_W{sel[i]}});
    end
    return c;
  endfunction

  // Lowest set bit of a mask, as one-hot.
  function automatic remap_mask_t lowest_bit(input remap_mask_t m);
    remap_mask_t r;
    r = '0;
    for (int i = NUM_REMAP - 1; i >= 0; i--) begin
      if (m[i]) begin
        r = '0;
        r[i] = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

>>> src/modifier_layer_key_remapper_top.sv
// ----------------------------------------------------------------------------
// modifier_layer_key_remapper_top - meta layer navigation key remapper
// Filters key events: while left meta is held, ten keys come out as
// navigation keys wrapped in meta release and press items.
// ----------------------------------------------------------------------------
// Usage
//   Input channel: in_valid_i / in_stall_o with event_type_i, event_code_i,
//   event_value_i. An item is taken at an edge where valid is high and stall
//   is low. Output channel: out_valid_o / out_stall_i with out_type_o,
//   out_code_o, out_value_o and last_of_run_o, high on the final result of
//   an item.
//   Each input item yields 1 to 11 result items. The first result passes
//   through the job register into the output register; further results
//   follow one per cycle while the receiver does not stall.
//   Throughput: results leave one per cycle while the receiver does not
//   stall, so plain pass-through items flow at one per cycle; a remapped
//   key or a layer release holds the sequencer until its last result. The
//   next item is taken in the cycle the last result of the current one
//   moves into the output register.
//   A stall on the output holds the output register and the sequencer;
//   the input then stalls once the single job slot is occupied.
//   Reset clears the layer flag, the held-key mask, the step counter and both valid bits.
// ----------------------------------------------------------------------------
module modifier_layer_key_remapper_top import mlkr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [TYPE_W-1:0]  event_type_i,
  input  logic [CODE_W-1:0]  event_code_i,
  input  logic [VALUE_W-1:0] event_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [TYPE_W-1:0]  out_type_o,
  output logic [CODE_W-1:0]  out_code_o,
  output logic [VALUE_W-1:0] out_value_o,
  output logic               last_of_run_o
);

  logic    accept;
  logic    busy;
  job_t    job;
  result_t result;

  // Stall while the sequencer still has results of the previous item to give.
  assign in_stall_o = busy;
  assign accept     = in_valid_i && !busy;

  // Classify the item and advance the layer state on accept.
  mlkr_decode u_decode (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .event_type_i  (event_type_i),
    .event_code_i  (event_code_i),
    .event_value_i (event_value_i),
    .job_o         (job)
  );

  // Walk the job out as result items through the output register.
  mlkr_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .job_i       (job),
    .busy_o      (busy),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .result_o    (result)
  );

  assign out_type_o    = result.ev_type;
  assign out_code_o    = result.ev_code;
  assign out_value_o   = result.ev_value;
  assign last_of_run_o = result.last;

endmodule

>>> src/mlkr_decode.sv
// ----------------------------------------------------------------------------
// mlkr_decode - event classification and layer state
// Classifies each accepted item into a job and keeps the layer flag and the
// held mask of remapped keys.
// ----------------------------------------------------------------------------
module mlkr_decode import mlkr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [TYPE_W-1:0]  event_type_i,
  input  logic [CODE_W-1:0]  event_code_i,
  input  logic [VALUE_W-1:0] event_value_i,
  output job_t               job_o
);

  logic        layer_q, layer_d;
  remap_mask_t held_q, held_d;

  remap_mask_t       match;
  logic              is_key;
  logic              is_meta;
  logic [VALUE_W-1:0] sat_value;

  assign is_key  = (event_type_i == EV_KEY);
  assign is_meta = (event_code_i == CODE_LMETA);
  assign match   = remap_match(event_code_i);

  // Negative values count as a release, anything above autorepeat clamps.
  always_comb begin
    if (event_value_i[VALUE_W-1]) begin
      sat_value = VAL_RELEASE;
    end else if (event_value_i > VAL_REPEAT) begin
      sat_value = VAL_REPEAT;
    end else begin
      sat_value = event_value_i;
    end
  end

  always_comb begin
    layer_d        = layer_q;
    held_d         = held_q;
    job_o.kind     = JOB_PASS;
    job_o.ev_type  = event_type_i;
    job_o.ev_code  = event_code_i;
    job_o.ev_value = event_value_i;
    job_o.mask     = '0;
    job_o.press    = 1'b0;
    if (is_key && layer_q && (match != '0)) begin
      if (sat_value != VAL_RELEASE) begin
        held_d = held_q | match;
      end else begin
        held_d = held_q & ~match;
      end
      job_o.kind     = JOB_REMAP;
      job_o.ev_type  = EV_KEY;
      job_o.ev_code  = remap_dst(match);
      job_o.ev_value = sat_value;
      job_o.press    = (held_d == '0);
    end else if (is_key && layer_q && is_meta && (event_value_i == VAL_RELEASE)) begin
      layer_d    = 1'b0;
      held_d     = '0;
      job_o.kind = JOB_META_REL;
      job_o.mask = held_q;
    end else if (is_key && !layer_q && is_meta && (event_value_i == VAL_PRESS)) begin
      layer_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      layer_q <= 1'b0;
      held_q  <= '0;
    end else if (accept_i) begin
      layer_q <= layer_d;
      held_q  <= held_d;
    end
  end

  // Keys only stay held while the layer is on.
  a_held_needs_layer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_q != '0) |-> layer_q)
    else $error("held remapped keys with layer off");

  // A layer release always leaves nothing held.
  a_meta_rel_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && job_o.kind == JOB_META_REL) |=> (held_q == '0) && !layer_q)
    else $error("layer release left state behind");

  // Press-back flag matches the held mask after a remapped item.
  a_press_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && job_o.kind == JOB_REMAP) |=> (held_q == '0) == $past(job_o.press))
    else $error("meta press flag disagrees with held mask");

endmodule

>>> src/mlkr_emit.sv
// ----------------------------------------------------------------------------
// mlkr_emit - result sequencer and output register
// Holds one job and walks it out as result items, one per free output slot.
// ----------------------------------------------------------------------------
module mlkr_emit import mlkr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    accept_i,
  input  job_t    job_i,
  output logic    busy_o,
  input  logic    out_stall_i,
  output logic    out_valid_o,
  output result_t result_o
);

  logic              job_valid_q;
  job_t              job_q;
  logic [STEP_W-1:0] step_q;
  logic              out_valid_q;
  result_t           out_q;

  result_t     res;
  remap_mask_t low;
  logic        slot_free;
  logic        fire;
  logic        done;

  assign low       = lowest_bit(job_q.mask);
  assign slot_free = !out_valid_q || !out_stall_i;
  assign fire      = job_valid_q && slot_free;
  assign done      = fire && res.last;
  // Hold off new items until the current job leaves its last result.
  assign busy_o    = job_valid_q && !done;

  always_comb begin
    res.ev_type  = job_q.ev_type;
    res.ev_code  = job_q.ev_code;
    res.ev_value = job_q.ev_value;
    res.last     = 1'b1;
    unique case (job_q.kind)
      JOB_PASS: begin
      end
      JOB_REMAP: begin
        res.ev_type = EV_KEY;
        if (step_q == STEP_W'(0)) begin
          res.ev_code  = CODE_LMETA;
          res.ev_value = VAL_RELEASE;
          res.last     = 1'b0;
        end else if (step_q == STEP_W'(1)) begin
          res.last = !job_q.press;
        end else begin
          res.ev_code  = CODE_LMETA;
          res.ev_value = VAL_PRESS;
        end
      end
      JOB_META_REL: begin
        res.ev_type  = EV_KEY;
        res.ev_value = VAL_RELEASE;
        if (job_q.mask != '0) begin
          res.ev_code = remap_dst(low);
          res.last    = 1'b0;
        end else begin
          res.ev_code = CODE_LMETA;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      step_q      <= '0;
    end else if (accept_i) begin
      job_valid_q <= 1'b1;
      step_q      <= '0;
    end else if (done) begin
      job_valid_q <= 1'b0;
    end else if (fire) begin
      step_q <= step_q + STEP_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      job_q <= job_i;
    end else if (fire) begin
      job_q.mask <= job_q.mask & ~low;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = out_q;

  a_remap_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (job_valid_q && job_q.kind == JOB_REMAP) |-> (step_q != STEP_W'(3)))
    else $error("remap job ran past its third result");

  a_fire_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("result lost on its way to the output register");

  a_mask_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (job_valid_q && !accept_i) |=> ((job_q.mask & ~$past(job_q.mask)) == '0))
    else $error("release mask gained a bit mid-job");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (job_valid_q && !done) |-> !accept_i)
    else $error("new item taken over an unfinished job");

endmodule
